[rtl/core/i2cm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants for the i2c master register access unit
// Word layouts of both channels, bus phase codes and register map.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // register map, index is paddr[2]
    localparam logic REG_IDX_HALF_PERIOD = 1'b0;
    localparam logic REG_IDX_ACK_TIMEOUT = 1'b1;
    localparam int   PADDR_W             = 3;

    // register reset values
    localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    // one tick of the bus, as presented on the input channel
    typedef struct packed {
        logic       go;
        logic       command;
        logic [6:0] dev_id;
        logic [7:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] length;
        logic       sda_in;
    } t_in_word;

    // pin levels and status of one tick
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       nack_error;
    } t_out_word;

    // bus phases, one-hot
    typedef enum logic [16:0] {
        PH_IDLE     = 17'b00000000000000001,
        PH_S_SETUP  = 17'b00000000000000010,
        PH_S_HOLD   = 17'b00000000000000100,
        PH_TX_LOW   = 17'b00000000000001000,
        PH_TX_HIGH  = 17'b00000000000010000,
        PH_ACK_LOW  = 17'b00000000000100000,
        PH_ACK_HIGH = 17'b00000000001000000,
        PH_RS_PREP  = 17'b00000000010000000,
        PH_RS_SETUP = 17'b00000000100000000,
        PH_RS_HOLD  = 17'b00000001000000000,
        PH_RX_LOW   = 17'b00000010000000000,
        PH_RX_HIGH  = 17'b00000100000000000,
        PH_MA_LOW   = 17'b00001000000000000,
        PH_MA_HIGH  = 17'b00010000000000000,
        PH_P_LOW    = 17'b00100000000000000,
        PH_P_HIGH   = 17'b01000000000000000,
        PH_P_REL    = 17'b10000000000000000
    } t_phase;

    // which byte is being sent out
    typedef enum logic [1:0] {
        KIND_DEVW = 2'd0,
        KIND_REG  = 2'd1,
        KIND_DAT  = 2'd2,
        KIND_DEVR = 2'd3
    } t_byte_kind;

endpackage

[rtl/core/i2cm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_core: bus phase sequencer
// Holds the transfer state and works out the pin levels and status of one
// tick; the state advances on every accepted word.
// ----------------------------------------------------------------------------
module i2cm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cm_pkg::t_in_word i_word,
    input  logic [15:0]        i_half_period,
    input  logic [7:0]         i_ack_timeout,
    output i2cm_pkg::t_out_word o_result
);
    import i2cm_pkg::*;

    t_phase     r_phase, n_phase, c_phase;
    t_byte_kind r_kind, n_kind;
    logic [15:0] r_tick, n_tick, c_tick;
    logic [7:0]  r_poll, n_poll, c_poll;
    logic [2:0]  r_bit, n_bit, c_bit;
    logic [7:0]  r_shift, n_shift, c_shift;
    logic [7:0]  r_left, n_left, c_left;
    logic [6:0]  r_dev, n_dev, c_dev;
    logic [7:0]  r_reg, n_reg, c_reg;
    logic [7:0]  r_dat, n_dat, c_dat;
    logic        r_rd, n_rd, c_rd;
    logic        r_err, n_err, c_err;

    logic        start;
    logic [15:0] hp;
    logic [7:0]  lim;
    logic [15:0] tick_inc;
    logic        tick_done;
    logic [15:0] tick_next;
    logic [7:0]  poll_inc;
    logic        poll_fail;
    logic [7:0]  rx_shift;
    logic        last_byte;
    t_out_word   res;

    // start of a transaction takes the command in the same tick
    assign start = (r_phase == PH_IDLE) && i_word.go;

    always_comb begin
        c_phase = r_phase;
        c_tick  = r_tick;
        c_poll  = r_poll;
        c_bit   = r_bit;
        c_shift = r_shift;
        c_left  = r_left;
        c_dev   = r_dev;
        c_reg   = r_reg;
        c_dat   = r_dat;
        c_rd    = r_rd;
        c_err   = r_err;
        if (start) begin
            c_phase = PH_S_SETUP;
            c_tick  = '0;
            c_poll  = '0;
            c_bit   = '0;
            c_shift = '0;
            c_left  = (i_word.length == 8'd0) ? 8'd1 : i_word.length;
            c_dev   = i_word.dev_id;
            c_reg   = i_word.reg_index;
            c_dat   = i_word.write_data;
            c_rd    = i_word.command;
            c_err   = 1'b0;
        end
    end

    // phase timer and ack poll counter
    assign hp        = (i_half_period == 16'd0) ? 16'd1 : i_half_period;
    assign lim       = (i_ack_timeout == 8'd0) ? 8'd1 : i_ack_timeout;
    assign tick_inc  = c_tick + 16'd1;
    assign tick_done = (tick_inc >= hp) || (tick_inc == 16'd0);
    assign tick_next = tick_done ? 16'd0 : tick_inc;
    assign poll_inc  = c_poll + 8'd1;
    assign poll_fail = (poll_inc >= lim) || (poll_inc == 8'd0);
    assign rx_shift  = {c_shift[6:0], i_word.sda_in};
    assign last_byte = (c_left <= 8'd1);

    // next state and pin levels of this tick
    always_comb begin
        n_phase = c_phase;
        n_kind  = r_kind;
        n_tick  = c_tick;
        n_poll  = c_poll;
        n_bit   = c_bit;
        n_shift = c_shift;
        n_left  = c_left;
        n_dev   = c_dev;
        n_reg   = c_reg;
        n_dat   = c_dat;
        n_rd    = c_rd;
        n_err   = c_err;
        res     = '0;
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;
        res.busy_res    = (c_phase != PH_IDLE);

        unique case (c_phase)
            PH_IDLE: begin
            end
            PH_S_SETUP: begin
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_S_HOLD;
                end
            end
            PH_S_HOLD: begin
                res.sda_release = 1'b0;
                n_tick = tick_next;
                if (tick_done) begin
                    n_shift = {c_dev, 1'b0};
                    n_bit   = '0;
                    n_kind  = KIND_DEVW;
                    n_phase = PH_TX_LOW;
                end
            end
            PH_TX_LOW: begin
                res.scl_release = 1'b0;
                res.sda_release = c_shift[7];
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_TX_HIGH;
                end
            end
            PH_TX_HIGH: begin
                res.sda_release = c_shift[7];
                n_tick = tick_next;
                if (tick_done) begin
                    n_shift = {c_shift[6:0], 1'b0};
                    n_bit   = c_bit + 3'd1;
                    n_phase = (c_bit == 3'd7) ? PH_ACK_LOW : PH_TX_LOW;
                end
            end
            PH_ACK_LOW: begin
                res.scl_release = 1'b0;
                n_tick = tick_next;
                if (tick_done) begin
                    n_poll  = '0;
                    n_phase = PH_ACK_HIGH;
                end
            end
            PH_ACK_HIGH: begin
                if (!i_word.sda_in) begin
                    n_poll = '0;
                    n_tick = '0;
                    case (r_kind)
                        KIND_DEVW: begin
                            n_shift = c_reg;
                            n_kind  = KIND_REG;
                            n_phase = PH_TX_LOW;
                        end
                        KIND_REG: begin
                            if (c_rd) begin
                                n_phase = PH_RS_PREP;
                            end else begin
                                n_shift = c_dat;
                                n_kind  = KIND_DAT;
                                n_phase = PH_TX_LOW;
                            end
                        end
                        KIND_DAT: begin
                            n_phase = PH_P_LOW;
                        end
                        default: begin
                            n_shift = '0;
                            n_bit   = '0;
                            n_phase = PH_RX_LOW;
                        end
                    endcase
                end else if (poll_fail) begin
                    n_poll  = '0;
                    n_err   = 1'b1;
                    n_tick  = '0;
                    n_phase = PH_P_LOW;
                end else begin
                    n_poll = poll_inc;
                end
            end
            PH_RS_PREP: begin
                res.scl_release = 1'b0;
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_RS_SETUP;
                end
            end
            PH_RS_SETUP: begin
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_RS_HOLD;
                end
            end
            PH_RS_HOLD: begin
                res.sda_release = 1'b0;
                n_tick = tick_next;
                if (tick_done) begin
                    n_shift = {c_dev, 1'b1};
                    n_bit   = '0;
                    n_kind  = KIND_DEVR;
                    n_phase = PH_TX_LOW;
                end
            end
            PH_RX_LOW: begin
                res.scl_release = 1'b0;
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_RX_HIGH;
                end
            end
            PH_RX_HIGH: begin
                n_tick = tick_next;
                if (tick_done) begin
                    n_shift = rx_shift;
                    n_bit   = c_bit + 3'd1;
                    if (c_bit == 3'd7) begin
                        res.read_data  = rx_shift;
                        res.read_valid = 1'b1;
                        res.read_last  = last_byte;
                        n_phase = PH_MA_LOW;
                    end else begin
                        n_phase = PH_RX_LOW;
                    end
                end
            end
            PH_MA_LOW: begin
                res.scl_release = 1'b0;
                res.sda_release = last_byte;
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_MA_HIGH;
                end
            end
            PH_MA_HIGH: begin
                res.sda_release = last_byte;
                n_tick = tick_next;
                if (tick_done) begin
                    if (last_byte) begin
                        n_left  = '0;
                        n_phase = PH_P_LOW;
                    end else begin
                        n_left  = c_left - 8'd1;
                        n_shift = '0;
                        n_phase = PH_RX_LOW;
                    end
                end
            end
            PH_P_LOW: begin
                res.scl_release = 1'b0;
                res.sda_release = 1'b0;
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_P_HIGH;
                end
            end
            PH_P_HIGH: begin
                res.sda_release = 1'b0;
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_P_REL;
                end
            end
            PH_P_REL: begin
                n_tick = tick_next;
                if (tick_done) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                res.busy_res = 1'b0;
                n_tick  = '0;
                n_phase = PH_IDLE;
            end
        endcase
        res.nack_error = n_err;
    end

    assign o_result = res;

    // state registers, advance once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= KIND_DEVW;
            r_tick  <= '0;
            r_poll  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_left  <= '0;
            r_dev   <= '0;
            r_reg   <= '0;
            r_dat   <= '0;
            r_rd    <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_tick  <= n_tick;
            r_poll  <= n_poll;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_left  <= n_left;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_dat   <= n_dat;
            r_rd    <= n_rd;
            r_err   <= n_err;
        end
    end

endmodule

[rtl/core/i2c_master_register_access_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit: i2c master for register write and read
// One input word is one bus tick; each word yields one output word with the
// pin levels, busy, received byte and error status of that tick.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------
//  input     | in        | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
//  output    | out       | o_out_valid / i_out_stall  | o_out_word (t_out_word)
//  config    | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
//  one word per cycle while the input is not stalled; a result is written to the
//  output register in the cycle after its word is accepted, by the single phase sequencer pass.
//  input is stalled only while the output register is full and stalled.
//  synchronous active-low reset returns the sequencer to idle and the
//  registers to half_period 5, ack_timeout 250.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit #(
    parameter logic [15:0] HALF_PERIOD_INIT = i2cm_pkg::HALF_PERIOD_RST,
    parameter logic [7:0]  ACK_TIMEOUT_INIT = i2cm_pkg::ACK_TIMEOUT_RST
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  i2cm_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output i2cm_pkg::t_out_word             o_out_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import i2cm_pkg::*;

    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;
    logic        r_out_valid;
    t_out_word   r_out_word;
    logic        in_accept;
    logic        cfg_write;
    t_out_word   step_result;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_INIT;
            r_ack_timeout <= ACK_TIMEOUT_INIT;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_IDX_HALF_PERIOD: r_half_period <= pwdata[15:0];
                REG_IDX_ACK_TIMEOUT: r_ack_timeout <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_IDX_HALF_PERIOD: prdata = {16'd0, r_half_period};
            REG_IDX_ACK_TIMEOUT: prdata = {24'd0, r_ack_timeout};
            default: prdata = '0;
        endcase
    end

    // phase sequencer
    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_accept),
        .i_word        (i_in_word),
        .i_half_period (r_half_period),
        .i_ack_timeout (r_ack_timeout),
        .o_result      (step_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[test/i2c_master_register_access_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit_checker: scoreboard for the i2c master
// Watches the input and output word channels and the register port. Every
// accepted input word runs one tick of a local model of the bus sequencer,
// and every accepted output word is compared field by field with the oldest
// predicted word.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  i2cm_pkg::t_in_word           i_in_word,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  i2cm_pkg::t_out_word          i_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [i2cm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output int                           o_fail_count,
    output logic                         o_bus_idle,
    output logic                         o_drained
);
    import i2cm_pkg::*;

    // local copies of the registers
    logic [15:0] half_period;
    logic [7:0]  ack_timeout;

    // sequencer state
    t_phase      bus_phase;
    t_byte_kind  byte_kind;
    logic [15:0] tick_cnt;
    logic [7:0]  poll_cnt;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  bytes_rem;
    logic [6:0]  hold_dev;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_wdata;
    logic        hold_read;
    logic        nack_flag;

    // predicted pin words, oldest first
    t_out_word   due_words[$];
    t_out_word   want;
    t_out_word   model_word;
    int          fail_cnt = 0;

    task automatic goto_phase(input t_phase ph);
        bus_phase = ph;
        tick_cnt  = 16'd0;
    endtask

    // one tick of a timed phase, high when the phase is over
    function automatic logic phase_done();
        logic [15:0] hp;
        hp       = (half_period == 16'd0) ? 16'd1 : half_period;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= hp || tick_cnt == 16'd0) begin
            tick_cnt = 16'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // slave acked, move on to the next byte or phase
    task automatic ack_received();
        case (byte_kind)
            KIND_DEVW: begin
                shreg     = hold_reg;
                byte_kind = KIND_REG;
                goto_phase(PH_TX_LOW);
            end
            KIND_REG: begin
                if (hold_read) begin
                    goto_phase(PH_RS_PREP);
                end else begin
                    shreg     = hold_wdata;
                    byte_kind = KIND_DAT;
                    goto_phase(PH_TX_LOW);
                end
            end
            KIND_DAT: begin
                goto_phase(PH_P_LOW);
            end
            default: begin
                shreg   = 8'd0;
                bit_idx = 3'd0;
                goto_phase(PH_RX_LOW);
            end
        endcase
    endtask

    // one bus tick: pin levels and status for the given input word
    task automatic step_sequencer(input t_in_word w, output t_out_word r);
        t_phase     p;
        logic       scl;
        logic       sda;
        logic [7:0] lim;
        r   = '0;
        scl = 1'b1;
        sda = 1'b1;
        // latch the command on a start while idle
        if (bus_phase == PH_IDLE && w.go) begin
            hold_read  = w.command;
            hold_dev   = w.dev_id;
            hold_reg   = w.reg_index;
            hold_wdata = w.write_data;
            bytes_rem  = (w.length == 8'd0) ? 8'd1 : w.length;
            nack_flag  = 1'b0;
            bit_idx    = 3'd0;
            poll_cnt   = 8'd0;
            shreg      = 8'd0;
            goto_phase(PH_S_SETUP);
        end
        p          = bus_phase;
        r.busy_res = (p != PH_IDLE);
        case (p)
            PH_IDLE: begin
            end
            PH_S_SETUP: begin
                if (phase_done()) goto_phase(PH_S_HOLD);
            end
            PH_S_HOLD: begin
                sda = 1'b0;
                if (phase_done()) begin
                    shreg     = {hold_dev, 1'b0};
                    bit_idx   = 3'd0;
                    byte_kind = KIND_DEVW;
                    goto_phase(PH_TX_LOW);
                end
            end
            PH_TX_LOW: begin
                scl = 1'b0;
                sda = shreg[7];
                if (phase_done()) goto_phase(PH_TX_HIGH);
            end
            PH_TX_HIGH: begin
                sda = shreg[7];
                if (phase_done()) begin
                    shreg = {shreg[6:0], 1'b0};
                    if (bit_idx == 3'd7) begin
                        bit_idx = 3'd0;
                        goto_phase(PH_ACK_LOW);
                    end else begin
                        bit_idx = bit_idx + 3'd1;
                        goto_phase(PH_TX_LOW);
                    end
                end
            end
            PH_ACK_LOW: begin
                scl = 1'b0;
                if (phase_done()) begin
                    poll_cnt = 8'd0;
                    goto_phase(PH_ACK_HIGH);
                end
            end
            PH_ACK_HIGH: begin
                // poll until the slave pulls sda low or the timeout runs out
                lim = (ack_timeout == 8'd0) ? 8'd1 : ack_timeout;
                if (!w.sda_in) begin
                    poll_cnt = 8'd0;
                    ack_received();
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                    if (poll_cnt >= lim || poll_cnt == 8'd0) begin
                        poll_cnt  = 8'd0;
                        nack_flag = 1'b1;
                        goto_phase(PH_P_LOW);
                    end
                end
            end
            PH_RS_PREP: begin
                scl = 1'b0;
                if (phase_done()) goto_phase(PH_RS_SETUP);
            end
            PH_RS_SETUP: begin
                if (phase_done()) goto_phase(PH_RS_HOLD);
            end
            PH_RS_HOLD: begin
                sda = 1'b0;
                if (phase_done()) begin
                    shreg     = {hold_dev, 1'b1};
                    bit_idx   = 3'd0;
                    byte_kind = KIND_DEVR;
                    goto_phase(PH_TX_LOW);
                end
            end
            PH_RX_LOW: begin
                scl = 1'b0;
                if (phase_done()) goto_phase(PH_RX_HIGH);
            end
            PH_RX_HIGH: begin
                // sample on the last tick of scl high
                if (phase_done()) begin
                    shreg = {shreg[6:0], w.sda_in};
                    if (bit_idx == 3'd7) begin
                        bit_idx      = 3'd0;
                        r.read_data  = shreg;
                        r.read_valid = 1'b1;
                        r.read_last  = (bytes_rem <= 8'd1);
                        goto_phase(PH_MA_LOW);
                    end else begin
                        bit_idx = bit_idx + 3'd1;
                        goto_phase(PH_RX_LOW);
                    end
                end
            end
            PH_MA_LOW, PH_MA_HIGH: begin
                // master ack, nack on the last byte
                scl = (p == PH_MA_HIGH);
                sda = (bytes_rem <= 8'd1);
                if (phase_done()) begin
                    if (p == PH_MA_LOW) begin
                        goto_phase(PH_MA_HIGH);
                    end else if (bytes_rem <= 8'd1) begin
                        bytes_rem = 8'd0;
                        goto_phase(PH_P_LOW);
                    end else begin
                        bytes_rem = bytes_rem - 8'd1;
                        shreg     = 8'd0;
                        goto_phase(PH_RX_LOW);
                    end
                end
            end
            PH_P_LOW: begin
                scl = 1'b0;
                sda = 1'b0;
                if (phase_done()) goto_phase(PH_P_HIGH);
            end
            PH_P_HIGH: begin
                sda = 1'b0;
                if (phase_done()) goto_phase(PH_P_REL);
            end
            PH_P_REL: begin
                if (phase_done()) goto_phase(PH_IDLE);
            end
            default: begin
                r.busy_res = 1'b0;
                goto_phase(PH_IDLE);
            end
        endcase
        r.scl_release = scl;
        r.sda_release = sda;
        r.nack_error  = nack_flag;
    endtask

    task automatic check_field(input string fname, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            fail_cnt++;
            $display("%0t: %s expected %0h actual %0h", $time, fname, exp_val, act_val);
        end
    endtask

    // watch the channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_period = HALF_PERIOD_RST;
            ack_timeout = ACK_TIMEOUT_RST;
            bus_phase   = PH_IDLE;
            byte_kind   = KIND_DEVW;
            tick_cnt    = 16'd0;
            poll_cnt    = 8'd0;
            bit_idx     = 3'd0;
            shreg       = 8'd0;
            bytes_rem   = 8'd0;
            hold_dev    = 7'd0;
            hold_reg    = 8'd0;
            hold_wdata  = 8'd0;
            hold_read   = 1'b0;
            nack_flag   = 1'b0;
            due_words.delete();
        end else begin
            // output word accepted
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: output word %h arrived with nothing expected",
                             $time, i_out_word);
                end else begin
                    want = due_words.pop_front();
                    check_field("scl_release", 8'(want.scl_release),
                                8'(i_out_word.scl_release));
                    check_field("sda_release", 8'(want.sda_release),
                                8'(i_out_word.sda_release));
                    check_field("busy_res", 8'(want.busy_res), 8'(i_out_word.busy_res));
                    check_field("read_data", want.read_data, i_out_word.read_data);
                    check_field("read_valid", 8'(want.read_valid),
                                8'(i_out_word.read_valid));
                    check_field("read_last", 8'(want.read_last), 8'(i_out_word.read_last));
                    check_field("nack_error", 8'(want.nack_error),
                                8'(i_out_word.nack_error));
                end
            end
            // input word accepted
            if (i_in_valid && !i_in_stall) begin
                step_sequencer(i_in_word, model_word);
                due_words.push_back(model_word);
            end
            // register write
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_IDX_HALF_PERIOD) begin
                    half_period = pwdata[15:0];
                end else begin
                    ack_timeout = pwdata[7:0];
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_bus_idle   <= (bus_phase == PH_IDLE);
        o_drained    <= (due_words.size() == 0);
    end

endmodule

[test/i2c_master_register_access_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit_tb: testbench top for the i2c master
// Drives bus ticks and register writes into the block, with random gaps on
// the input side and random stalls on the output side, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit_tb;
    import i2cm_pkg::*;

    localparam logic CMD_WRITE       = 1'b0;
    localparam logic CMD_READ        = 1'b1;
    localparam int   RAND_PHASES     = 3;
    localparam int   TICKS_PER_PHASE = 120;
    localparam int   QUIET_TICKS     = 60;
    localparam int   HOLD_AT_CYCLE   = 600;
    localparam int   HOLD_CYCLES     = 120;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_word          o_out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int                 fail_count;
    logic               bus_idle;
    logic               drained;
    int                 gap_pct    = 0;
    logic               quiet_tail = 1'b0;

    i2c_master_register_access_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    i2c_master_register_access_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_bus_idle   (bus_idle),
        .o_drained    (drained)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // random tick, sda_in high with bias percent, longer reads only when asked
    function automatic t_in_word rand_tick(input int bias, input logic allow_long);
        t_in_word w;
        w.go         = ($urandom_range(0, 3) != 0);
        w.command    = 1'($urandom_range(0, 1));
        w.dev_id     = 7'($urandom_range(0, 127));
        w.reg_index  = 8'($urandom_range(0, 255));
        w.write_data = 8'($urandom_range(0, 255));
        if (allow_long && $urandom_range(0, 39) == 0) begin
            w.length = 8'($urandom_range(5, 16));
        end else begin
            w.length = 8'($urandom_range(0, 4));
        end
        w.sda_in = ($urandom_range(0, 99) < bias);
        return w;
    endfunction

    // offer one word, called and returning at a falling edge
    task automatic send_tick(input t_in_word w);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // finish the running transaction, then wait for every output word
    task automatic run_to_idle(input int bias);
        t_in_word w;
        while (!bus_idle) begin
            w    = rand_tick(bias, 1'b0);
            w.go = 1'b0;
            send_tick(w);
        end
        i_in_valid <= 1'b0;
        while (!drained) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] hp, input logic [7:0] ack,
                              input int bias);
        run_to_idle(bias);
        reg_write(REG_IDX_HALF_PERIOD, {16'd0, hp});
        reg_write(REG_IDX_ACK_TIMEOUT, {24'd0, ack});
    endtask

    // one directed transaction from idle to idle, go noise while busy
    task automatic run_xfer(input logic cmd, input logic [6:0] dev,
                            input logic [7:0] ra, input logic [7:0] wd,
                            input logic [7:0] len, input int bias);
        t_in_word w;
        w            = rand_tick(bias, 1'b0);
        w.go         = 1'b1;
        w.command    = cmd;
        w.dev_id     = dev;
        w.reg_index  = ra;
        w.write_data = wd;
        w.length     = len;
        send_tick(w);
        while (!bus_idle) send_tick(rand_tick(bias, 1'b0));
    endtask

    // output side: random stall bursts and one long hold-off
    initial begin : receiver
        int cyc;
        int stall_pct;
        cyc         = 0;
        stall_pct   = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 200 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 4;
                    default: stall_pct = 20;
                endcase
            end
            if (cyc == HOLD_AT_CYCLE) begin
                // long hold-off so the output register fills and the input stalls
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [15:0] hp;
        logic [7:0]  ack;
        int          bias;
        t_in_word    idle_w;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset settings: field maxima
        gap_pct = 10;
        run_xfer(CMD_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'd1, 5);

        // shortest phases, longest timeout: zero length, slow ack and a timeout
        set_config(16'd1, 8'd255, 50);
        run_xfer(CMD_READ, 7'h00, 8'h00, 8'h00, 8'd0, 50);
        run_xfer(CMD_READ, 7'h01, 8'h80, 8'h7F, 8'd2, 90);
        run_xfer(CMD_WRITE, 7'h40, 8'h01, 8'h80, 8'd1, 100);

        // zero half period and zero timeout
        set_config(16'd0, 8'd0, 50);
        run_xfer(CMD_READ, 7'h33, 8'hCC, 8'h11, 8'd4, 0);
        run_xfer(CMD_WRITE, 7'h0F, 8'hF0, 8'h5A, 8'd1, 50);
        run_xfer(CMD_READ, 7'h6C, 8'h3C, 8'hC3, 8'd1, 50);

        // largest half period, idle ticks only
        set_config(16'hFFFF, 8'd1, 50);
        repeat (16) begin
            idle_w    = rand_tick(50, 1'b0);
            idle_w.go = 1'b0;
            send_tick(idle_w);
        end

        // random phases, mostly fast settings
        bias = 50;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: hp = 16'd1;
                4, 5:       hp = 16'd2;
                6:          hp = 16'd0;
                default:    hp = 16'($urandom_range(3, 6));
            endcase
            case ($urandom_range(0, 5))
                0:       ack = 8'd0;
                1:       ack = 8'd1;
                2:       ack = 8'd2;
                3:       ack = 8'd255;
                default: ack = 8'($urandom_range(3, 40));
            endcase
            set_config(hp, ack, bias);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 5;
                default: gap_pct = 25;
            endcase
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                if (k % 64 == 0) begin
                    case ($urandom_range(0, 4))
                        0:       bias = 5;
                        1, 2:    bias = 50;
                        3:       bias = 85;
                        default: bias = 98;
                    endcase
                end
                if (ph == RAND_PHASES - 1 && k >= TICKS_PER_PHASE - QUIET_TICKS) begin
                    quiet_tail = 1'b1;
                end
                send_tick(rand_tick(bias, hp <= 16'd2));
            end
        end

        run_to_idle(bias);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("i2c_master_register_access_unit: match");
        end else begin
            $display("i2c_master_register_access_unit: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #2_000_000;
        $display("i2c_master_register_access_unit: mismatch");
        $finish;
    end

endmodule

[i2c_master_register_access_unit.f]
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_core.sv
rtl/core/i2c_master_register_access_unit.sv
test/i2c_master_register_access_unit_checker.sv
test/i2c_master_register_access_unit_tb.sv
